/* rtl/chd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chd_pkg
// Shared types, character codes and the hex digit decoder for the chunked
// body decoder.
// ----------------------------------------------------------------------------
package chd_pkg;

    typedef enum logic [2:0] {
        PH_SIZE     = 3'd0,
        PH_SIZE_CR  = 3'd1,
        PH_DATA     = 3'd2,
        PH_DATA_END = 3'd3,
        PH_DATA_CR  = 3'd4,
        PH_DONE     = 3'd5,
        PH_ERROR    = 3'd6
    } phase_t;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // bits per hex digit of the size field
    localparam int RADIX_BITS = 4;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       chunk_last;
        logic       body_end;
        logic       frame_error;
    } result_t;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        d.is_hex = 1'b1;
        d.value  = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d.value = c[3:0];
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            // 'a'..'f' and 'A'..'F' share the low nibble 1..6
            d.value = c[3:0] + 4'd9;
        end
        else
        begin
            d.is_hex = 1'b0;
        end
        return d;
    endfunction

endpackage

/* rtl/http_chunked_body_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Decodes an HTTP chunked body one byte per cycle while the output is not stalled, one result per byte.
// ----------------------------------------------------------------------------
// Takes one body byte per clock and returns one result per byte; each byte
// is held in the input register until the result register, once free, loads
// its result. A new byte can be taken every cycle; the only thing that holds
// the input back is a result still waiting at the output. Chunk sizes are
// hex, SIZE_BITS wide at most; payload bytes come out with payload_valid,
// chunk_last marks the last one of a chunk. body_end and frame_error stick
// until reset.
module http_chunked_body_decoder #(
    parameter int SIZE_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    output logic        data_ready,
    input  logic [7:0]  data_byte,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [7:0]  payload_byte,
    output logic        payload_valid,
    output logic        chunk_last,
    output logic        body_end,
    output logic        frame_error
);

    logic               in_valid_reg;
    logic               in_valid_next;
    logic [7:0]         in_byte_reg;
    logic               out_free;
    logic               advance;
    chd_pkg::result_t   step_result;
    chd_pkg::result_t   held_result;

    assign advance       = in_valid_reg && out_free;
    assign data_ready    = !in_valid_reg || out_free;
    assign in_valid_next = (data_valid && data_ready) ? 1'b1
                         : (advance ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_valid && data_ready)
        begin
            in_byte_reg <= data_byte;
        end
    end

    chd_parser #(
        .SIZE_BITS (SIZE_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .data_byte (in_byte_reg),
        .result    (step_result)
    );

    chd_out_reg u_out_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance),
        .result_in    (step_result),
        .free         (out_free),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_out   (held_result)
    );

    assign payload_byte  = held_result.payload_byte;
    assign payload_valid = held_result.payload_valid;
    assign chunk_last    = held_result.chunk_last;
    assign body_end      = held_result.body_end;
    assign frame_error   = held_result.frame_error;

endmodule

/* rtl/chd_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chd_parser
// Chunk framing state machine: size line parsing, payload counting and
// line end checks. Produces the result for the byte in the input register.
// ----------------------------------------------------------------------------
module chd_parser #(
    parameter int SIZE_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic [7:0]         data_byte,
    output chd_pkg::result_t   result
);

    chd_pkg::phase_t        phase_reg;
    chd_pkg::phase_t        phase_next;
    logic [SIZE_BITS-1:0]   size_acc_reg;
    logic [SIZE_BITS-1:0]   size_acc_next;
    logic [SIZE_BITS-1:0]   remaining_reg;
    logic [SIZE_BITS-1:0]   remaining_next;
    logic                   digit_seen_reg;
    logic                   digit_seen_next;

    chd_pkg::hex_digit_t    digit;
    logic                   acc_full;
    logic [SIZE_BITS-1:0]   remaining_dec;

    assign digit    = chd_pkg::hex_decode(data_byte);
    // one more digit would not fit
    assign acc_full = |size_acc_reg[SIZE_BITS-1:SIZE_BITS-chd_pkg::RADIX_BITS];
    assign remaining_dec = (remaining_reg != '0) ? remaining_reg - 1'b1 : '0;

    // next state
    always_comb
    begin
        phase_next      = phase_reg;
        size_acc_next   = size_acc_reg;
        remaining_next  = remaining_reg;
        digit_seen_next = digit_seen_reg;
        unique case (phase_reg)
            chd_pkg::PH_SIZE,
            chd_pkg::PH_SIZE_CR:
            begin
                if (phase_reg == chd_pkg::PH_SIZE && digit.is_hex)
                begin
                    if (acc_full)
                    begin
                        phase_next = chd_pkg::PH_ERROR;
                    end
                    else
                    begin
                        size_acc_next   = {size_acc_reg[SIZE_BITS-chd_pkg::RADIX_BITS-1:0],
                                           digit.value};
                        digit_seen_next = 1'b1;
                    end
                end
                else if (phase_reg == chd_pkg::PH_SIZE && data_byte == chd_pkg::CH_CR)
                begin
                    phase_next = chd_pkg::PH_SIZE_CR;
                end
                else if (data_byte == chd_pkg::CH_LF)
                begin
                    // end of size line
                    if (!digit_seen_reg)
                    begin
                        phase_next    = chd_pkg::PH_SIZE;
                        size_acc_next = '0;
                    end
                    else if (size_acc_reg == '0)
                    begin
                        phase_next = chd_pkg::PH_DONE;
                    end
                    else
                    begin
                        remaining_next  = size_acc_reg;
                        size_acc_next   = '0;
                        digit_seen_next = 1'b0;
                        phase_next      = chd_pkg::PH_DATA;
                    end
                end
                else
                begin
                    phase_next = chd_pkg::PH_ERROR;
                end
            end
            chd_pkg::PH_DATA:
            begin
                remaining_next = remaining_dec;
                if (remaining_dec == '0)
                begin
                    phase_next = chd_pkg::PH_DATA_END;
                end
            end
            chd_pkg::PH_DATA_END,
            chd_pkg::PH_DATA_CR:
            begin
                if (phase_reg == chd_pkg::PH_DATA_END && data_byte == chd_pkg::CH_CR)
                begin
                    phase_next = chd_pkg::PH_DATA_CR;
                end
                else if (data_byte == chd_pkg::CH_LF)
                begin
                    phase_next      = chd_pkg::PH_SIZE;
                    size_acc_next   = '0;
                    digit_seen_next = 1'b0;
                end
                else
                begin
                    phase_next = chd_pkg::PH_ERROR;
                end
            end
            chd_pkg::PH_DONE:
            begin
                phase_next = chd_pkg::PH_DONE;
            end
            default:
            begin
                phase_next = chd_pkg::PH_ERROR;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        result.payload_byte  = 8'd0;
        result.payload_valid = 1'b0;
        result.chunk_last    = 1'b0;
        unique case (phase_reg)
            chd_pkg::PH_DATA:
            begin
                result.payload_byte  = data_byte;
                result.payload_valid = 1'b1;
                result.chunk_last    = (remaining_dec == '0);
            end
            default:
            begin
                result.payload_valid = 1'b0;
            end
        endcase
        result.body_end    = (phase_next == chd_pkg::PH_DONE);
        result.frame_error = (phase_next == chd_pkg::PH_ERROR);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= chd_pkg::PH_SIZE;
            size_acc_reg   <= '0;
            remaining_reg  <= '0;
            digit_seen_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg      <= phase_next;
            size_acc_reg   <= size_acc_next;
            remaining_reg  <= remaining_next;
            digit_seen_reg <= digit_seen_next;
        end
    end

`ifndef ASSERT_OFF
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == chd_pkg::PH_DONE |=> phase_reg == chd_pkg::PH_DONE)
        else $error("done phase left");

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == chd_pkg::PH_ERROR |=> phase_reg == chd_pkg::PH_ERROR)
        else $error("error phase left");

    a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == chd_pkg::PH_DATA |-> remaining_reg != '0)
        else $error("payload phase with zero count");

    a_last_ends_data: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.chunk_last |=> phase_reg == chd_pkg::PH_DATA_END)
        else $error("chunk end did not close payload");
`endif

endmodule

/* rtl/chd_out_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chd_out_reg
// Result register with valid/ready handshake; frees in the same cycle that
// the held result is taken.
// ----------------------------------------------------------------------------
module chd_out_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  chd_pkg::result_t   result_in,
    output logic               free,
    output logic               result_valid,
    input  logic               result_ready,
    output chd_pkg::result_t   result_out
);

    logic               valid_reg;
    logic               valid_next;
    chd_pkg::result_t   result_reg;

    assign free       = !valid_reg || result_ready;
    assign valid_next = load ? 1'b1 : (result_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

    assign result_valid = valid_reg;
    assign result_out   = result_reg;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("result overwritten before taken");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !result_ready |=> valid_reg && $stable(result_reg))
        else $error("stalled result changed");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> !(result_reg.body_end && result_reg.frame_error))
        else $error("done and error together");
`endif

endmodule
